[design/u8dec_pkg.sv]
// Shared types, constants and helper functions for the lenient UTF-8 decoder.
package u8dec_pkg;

   localparam int ByteW      = 8;
   localparam int ContW      = 6;
   localparam int MaxCont    = 7;
   localparam int CountW     = 3;
   localparam int CodeW      = 31;
   localparam int DataW      = 32;
   localparam int StepW      = 4;
   localparam int QueueDepth = 2;

   // Longest sequence that is assembled; longer ones always fall back.
   localparam logic [CountW-1:0] MaxShortNeed = 3'd5;
   localparam logic [ByteW-1:0]  ContMarker   = 8'h80;
   localparam logic [ByteW-1:0]  LeadMask     = 8'h7F;

   typedef logic [MaxCont-1:0][ContW-1:0] conts_type;

   // One unit of work for the emitter: an optional fallback (lead byte and
   // buffered continuation bytes, replayed raw), then an optional tail word.
   typedef struct packed {
      logic                 fallback;
      logic [ByteW-1:0]     lead;
      logic [CountW-1:0]    ncont;
      conts_type            conts;
      logic                 tail_valid;
      logic [CodeW-1:0]     tail;
   } job_type;

   // Number of continuation bytes that a lead byte of 0xC0 or above calls for.
   function automatic logic [CountW-1:0] needed_for(input logic [ByteW-1:0] lead);
      logic [CountW-1:0] k;
      if (!lead[5]) begin
         k = 3'd1;
      end else if (!lead[4]) begin
         k = 3'd2;
      end else if (!lead[3]) begin
         k = 3'd3;
      end else if (!lead[2]) begin
         k = 3'd4;
      end else if (!lead[1]) begin
         k = 3'd5;
      end else if (!lead[0]) begin
         k = 3'd6;
      end else begin
         k = 3'd7;
      end
      return k;
   endfunction

   // Builds the code point of a completed sequence of one to five continuations.
   function automatic logic [CodeW-1:0] assemble(input logic [ByteW-1:0]  lead,
                                                 input conts_type         conts,
                                                 input logic [CountW-1:0] k);
      logic [ByteW-1:0]  lsh;
      logic [DataW-1:0]  lp;
      logic [DataW-1:0]  res;
      lsh = (lead << k) & LeadMask;
      lp  = {24'd0, lsh};
      case (k)
         3'd1: res = (lp << 5)  | {26'd0, conts[0]};
         3'd2: res = (lp << 10) | {20'd0, conts[0], conts[1]};
         3'd3: res = (lp << 15) | {14'd0, conts[0], conts[1], conts[2]};
         3'd4: res = (lp << 20) | {8'd0, conts[0], conts[1], conts[2], conts[3]};
         3'd5: res = (lp << 25) | {2'd0, conts[0], conts[1], conts[2], conts[3],
                                   conts[4]};
         default: res = '0;
      endcase
      return res[CodeW-1:0];
   endfunction

endpackage

[design/utf8_lenient_decoder.sv]
// Lenient six-byte UTF-8 decoder top level: front end, job queue and emitter.
// Words pass from the job queue through the emitter's job register to its output register.
// Throughput: one byte per cycle while each byte yields at most one word and the output
// is ready; a fallback of n words holds the emitter, and the job queue absorbs that until
// it fills. The emitter, one word per cycle unless stalled, sets the sustained rate.
// Reset (synchronous, active high) closes any open sequence and empties queue and output.
module utf8_lenient_decoder #(
   parameter int QueueDepth = u8dec_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_text
   // Code point output channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] code_point, [31] zero
   output logic        rsp_tlast    // last_of_run
);

   logic                        accept;
   logic                        push;
   u8dec_pkg::job_type          push_job;
   logic                        queue_full;
   logic                        queue_valid;
   u8dec_pkg::job_type          queue_head;
   logic                        queue_pop;
   logic [u8dec_pkg::CodeW-1:0] code_point;

   // A byte is taken whenever the queue has room for the job it may create.
   // Bytes that only open or extend a sequence create no job at all.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // The front end holds the pending sequence (lead byte, counts and the
   // buffered continuation payloads) and settles each byte in the cycle it
   // is accepted: a completed code point, a fallback replay, a raw byte, or
   // a combination of a fallback and the byte that broke the sequence.
   u8dec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .end_of_text (req_tlast),
      .push        (push),
      .job         (push_job)
   );

   // Jobs carry a copy of everything the emitter needs, so the front end
   // can move on to the next sequence while a replay is still going out.
   u8dec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .valid    (queue_valid),
      .head     (queue_head)
   );

   // The emitter walks through a job one word at a time and flags the final
   // word of each job, which is the final word caused by its input byte.
   u8dec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (queue_head),
      .job_pop   (queue_pop),
      .out_valid (rsp_tvalid),
      .out_code  (code_point),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, code_point};

endmodule

[design/u8dec_front.sv]
// Front end: tracks the open sequence and turns each byte into emitter jobs.
module u8dec_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [u8dec_pkg::ByteW-1:0] in_byte,
   input  logic                        end_of_text,
   output logic                        push,
   output u8dec_pkg::job_type          job
);

   logic                          in_seq_ff, in_seq_in;
   logic [u8dec_pkg::ByteW-1:0]   lead_ff, lead_in;
   logic [u8dec_pkg::CountW-1:0]  need_ff, need_in;
   logic [u8dec_pkg::CountW-1:0]  seen_ff, seen_in;
   u8dec_pkg::conts_type          cont_bits_ff, cont_bits_in;

   u8dec_pkg::conts_type          conts_new;
   logic [u8dec_pkg::CountW-1:0]  seen_plus;
   logic                          is_cont;
   logic                          starts;

   always_comb begin
      is_cont   = (in_byte[7:6] == 2'b10);
      starts    = (in_byte[7:6] == 2'b11) && !end_of_text;
      seen_plus = seen_ff + 3'd1;
      conts_new = cont_bits_ff;
      conts_new[seen_ff] = in_byte[u8dec_pkg::ContW-1:0];

      in_seq_in    = in_seq_ff;
      lead_in      = lead_ff;
      need_in      = need_ff;
      seen_in      = seen_ff;
      cont_bits_in = cont_bits_ff;
      push         = 1'b0;
      job          = '0;

      if (accept) begin
         if (in_seq_ff && is_cont) begin
            cont_bits_in = conts_new;
            seen_in      = seen_plus;
            if (seen_plus >= need_ff || end_of_text) begin
               in_seq_in = 1'b0;
               seen_in   = '0;
               need_in   = '0;
               push      = 1'b1;
               if (seen_plus >= need_ff && need_ff <= u8dec_pkg::MaxShortNeed) begin
                  job.tail_valid = 1'b1;
                  job.tail       = u8dec_pkg::assemble(lead_ff, conts_new, need_ff);
               end else begin
                  // Sequence too long, or cut short by the end of the text.
                  job.fallback = 1'b1;
                  job.lead     = lead_ff;
                  job.ncont    = seen_plus;
                  job.conts    = conts_new;
               end
            end
         end else begin
            if (in_seq_ff) begin
               // A non-continuation byte breaks the open sequence.
               job.fallback = 1'b1;
               job.lead     = lead_ff;
               job.ncont    = seen_ff;
               job.conts    = cont_bits_ff;
               push         = 1'b1;
            end
            in_seq_in = 1'b0;
            seen_in   = '0;
            need_in   = '0;
            if (starts) begin
               in_seq_in = 1'b1;
               lead_in   = in_byte;
               need_in   = u8dec_pkg::needed_for(in_byte);
            end else begin
               job.tail_valid = 1'b1;
               job.tail       = {23'd0, in_byte};
               push           = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_seq_ff <= 1'b0;
         lead_ff   <= '0;
         need_ff   <= '0;
         seen_ff   <= '0;
      end else begin
         in_seq_ff <= in_seq_in;
         lead_ff   <= lead_in;
         need_ff   <= need_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      cont_bits_ff <= cont_bits_in;
   end

endmodule

[design/u8dec_queue.sv]
// Small job queue between the front end and the emitter.
module u8dec_queue #(
   parameter int Depth = u8dec_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8dec_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output u8dec_pkg::job_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   u8dec_pkg::job_type        entry_ff [Depth];
   logic [PtrW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]           count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   always_comb begin
      full    = (count_ff == FullCnt);
      valid   = (count_ff != '0);
      head    = entry_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/u8dec_back.sv]
// Emitter: plays out each job one word per cycle, while out_ready allows, into the output register.
module u8dec_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  u8dec_pkg::job_type          job,
   output logic                        job_pop,
   output logic                        out_valid,
   output logic [u8dec_pkg::CodeW-1:0] out_code,
   output logic                        out_last,
   input  logic                        out_ready
);

   u8dec_pkg::job_type            job_ff, job_in;
   logic                          busy_ff, busy_in;
   logic [u8dec_pkg::StepW-1:0]   step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   logic [u8dec_pkg::CodeW-1:0]   out_code_ff, out_code_in;
   logic                          out_last_ff, out_last_in;

   logic                          can_load;
   logic [u8dec_pkg::StepW-1:0]   total;
   logic [u8dec_pkg::StepW-1:0]   step_next;
   logic [u8dec_pkg::CountW-1:0]  cont_idx;
   logic [u8dec_pkg::CodeW-1:0]   word;
   logic                          word_last;

   always_comb begin
      can_load  = !out_valid_ff || out_ready;
      total     = {3'd0, job_ff.fallback} + {1'b0, job_ff.ncont}
                  + {3'd0, job_ff.tail_valid};
      step_next = step_ff + 4'd1;
      word_last = (step_next == total);
      cont_idx  = step_ff[u8dec_pkg::CountW-1:0] - 3'd1;

      if (job_ff.fallback && step_ff == '0) begin
         word = {23'd0, job_ff.lead};
      end else if (job_ff.fallback && step_ff <= {1'b0, job_ff.ncont}) begin
         word = {23'd0, u8dec_pkg::ContMarker | {2'b00, job_ff.conts[cont_idx]}};
      end else begin
         word = job_ff.tail;
      end

      job_pop = job_valid && (!busy_ff || (can_load && word_last));

      job_in  = job_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (busy_ff && can_load) begin
         step_in = step_next;
         if (word_last) begin
            busy_in = 1'b0;
         end
      end
      if (job_pop) begin
         job_in  = job;
         busy_in = 1'b1;
         step_in = '0;
      end

      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      if (can_load) begin
         out_valid_in = busy_ff;
         out_code_in  = word;
         out_last_in  = word_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_code  = out_code_ff;
   assign out_last  = out_last_ff;

endmodule
